/* hdl/assert_macros.svh */
// assertion helpers, clocked on clk and held off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds in the same cycle
`define ASSERT_NOW(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/simon_pkg.sv */
`default_nettype none

package simon_pkg;

    // cipher geometry
    localparam int WORD_BITS  = 32;
    localparam int KEY_WORDS  = 4;
    localparam int MAX_ROUNDS = 44;

    // configuration port
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int KEY_REGS    = 4;
    localparam int ROUND_CNT_W = 6;
    localparam int SEQ_W       = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_0  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_1  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_2  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_3  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ROUND_COUNT = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SEQ_SELECT  = 3'd5;

    localparam logic [ROUND_CNT_W-1:0] ROUND_COUNT_RST = ROUND_CNT_W'(44);
    localparam logic [SEQ_W-1:0]       SEQ_SELECT_RST  = SEQ_W'(3);

    // derived widths
    localparam int KIDX_W  = $clog2(MAX_ROUNDS);
    localparam int ROUND_W = $clog2(MAX_ROUNDS + 1);
    localparam int BIT_W   = $clog2(WORD_BITS);

    // round function taps, as seen on a word rotated right once per bit
    localparam int TAP_ROT1 = WORD_BITS - 1;
    localparam int TAP_ROT2 = WORD_BITS - 2;
    localparam int TAP_ROT8 = WORD_BITS - 8;

    // key schedule rotations and constant
    localparam int KS_ROT_A = 3;
    localparam int KS_ROT_B = 1;
    localparam int KS_CONST = 3;

    // z constant sequences, first symbol in the top bit
    localparam int SEQ_COUNT = 5;
    localparam int Z_LEN     = 62;
    localparam int Z_W       = $clog2(Z_LEN);

    localparam logic [Z_LEN-1:0] Z_SEQ [SEQ_COUNT] = '{
        62'b11111010001001010110000111001101111101000100101011000011100110,
        62'b10001110111110010011000010110101000111011111001001100001011010,
        62'b10101111011100000011010010011000101000010001111110010110110011,
        62'b11011011101011000110010111100000010010001010011100110100001111,
        62'b11010001111001101011011000100000010111000011001010010011101111
    };

    typedef logic [WORD_BITS-1:0] word_t;

    // one write into the round key store
    typedef struct packed {
        logic              en;
        logic [KIDX_W-1:0] addr;
        word_t             data;
    } key_wr_t;

    // sequencer controls for the bit-serial round datapath
    typedef struct packed {
        logic load;
        logic key_load;
        logic step;
        logic round_last;
    } dp_ctrl_t;

    // z sequence symbol; unknown selectors fall back to the last sequence
    function automatic logic z_bit(input logic [SEQ_W-1:0] sel, input logic [Z_W-1:0] idx);
        logic [SEQ_W-1:0] s;
        logic [Z_W-1:0]   pos;
        s   = (sel > SEQ_W'(SEQ_COUNT - 1)) ? SEQ_W'(SEQ_COUNT - 1) : sel;
        pos = Z_W'(Z_LEN - 1) - idx;
        return Z_SEQ[s][pos];
    endfunction

endpackage

`default_nettype wire

/* hdl/simon_ram.sv */
`default_nettype none

module simon_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 44
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // single write port, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* hdl/simon_key_sched.sv */
`default_nettype none

module simon_key_sched
    import simon_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   go,
    input  wire word_t [KEY_REGS-1:0]   key_words,
    input  wire logic [SEQ_W-1:0]       seq_sel,
    output key_wr_t                     key_wr,
    output logic                        done
);

    logic              active_reg;
    logic [KIDX_W-1:0] cnt_reg;
    logic [Z_W-1:0]    zidx_reg;
    word_t             win_reg [KEY_WORDS];

    word_t      t_mix;
    word_t      t_fold;
    word_t      rk;
    logic [1:0] kw_sel;

    // next round key from the window of the last few keys
    always_comb
    begin
        kw_sel = 2'(KEY_WORDS - 1) - cnt_reg[1:0];
        t_mix  = {win_reg[KEY_WORDS-1][KS_ROT_A-1:0],
                  win_reg[KEY_WORDS-1][WORD_BITS-1:KS_ROT_A]};
        if (KEY_WORDS == 4)
        begin
            t_mix = t_mix ^ win_reg[1];
        end
        t_fold = t_mix ^ {t_mix[KS_ROT_B-1:0], t_mix[WORD_BITS-1:KS_ROT_B]};
        if (cnt_reg < KIDX_W'(KEY_WORDS))
        begin
            rk = key_words[kw_sel];
        end
        else
        begin
            rk = ~win_reg[0] ^ t_fold ^ word_t'(z_bit(seq_sel, zidx_reg))
                 ^ word_t'(KS_CONST);
        end
    end

    assign done        = active_reg && (cnt_reg == KIDX_W'(MAX_ROUNDS - 1));
    assign key_wr.en   = active_reg;
    assign key_wr.addr = cnt_reg;
    assign key_wr.data = rk;

    // sweep counter, one key per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
            zidx_reg   <= '0;
        end
        else if (go)
        begin
            active_reg <= 1'b1;
            cnt_reg    <= '0;
            zidx_reg   <= '0;
        end
        else if (active_reg)
        begin
            cnt_reg <= cnt_reg + KIDX_W'(1);
            if (done)
            begin
                active_reg <= 1'b0;
            end
            if (cnt_reg >= KIDX_W'(KEY_WORDS))
            begin
                zidx_reg <= (zidx_reg == Z_W'(Z_LEN - 1)) ? '0 : zidx_reg + Z_W'(1);
            end
        end
    end

    // window of recent round keys
    always_ff @(posedge clk)
    begin
        if (active_reg)
        begin
            for (int j = 0; j < KEY_WORDS - 1; j++)
            begin
                win_reg[j] <= win_reg[j+1];
            end
            win_reg[KEY_WORDS-1] <= rk;
        end
    end

endmodule

`default_nettype wire

/* hdl/simon_round_serial.sv */
`default_nettype none

module simon_round_serial
    import simon_pkg::*;
(
    input  wire logic     clk,
    input  wire dp_ctrl_t ctrl,
    input  wire logic     func,
    input  wire word_t    left_in,
    input  wire word_t    right_in,
    input  wire word_t    key,
    output word_t         left_out,
    output word_t         right_out
);

    // a rotates through the round untouched, b is rewritten one bit per cycle
    word_t a_reg;
    word_t b_reg;
    word_t k_reg;
    logic  dec_reg;

    word_t a_rot;
    word_t b_shift;
    logic  new_bit;

    always_comb
    begin
        new_bit = (a_reg[TAP_ROT1] & a_reg[TAP_ROT8]) ^ a_reg[TAP_ROT2] ^ k_reg[0] ^ b_reg[0];
        a_rot   = {a_reg[0], a_reg[WORD_BITS-1:1]};
        b_shift = {new_bit, b_reg[WORD_BITS-1:1]};
    end

    // decrypt runs the same round on swapped halves
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            dec_reg <= func;
            a_reg   <= func ? right_in : left_in;
            b_reg   <= func ? left_in : right_in;
        end
        else if (ctrl.step)
        begin
            if (ctrl.round_last)
            begin
                a_reg <= b_shift;
                b_reg <= a_rot;
            end
            else
            begin
                a_reg <= a_rot;
                b_reg <= b_shift;
            end
        end

        if (ctrl.key_load)
        begin
            k_reg <= key;
        end
        else if (ctrl.step)
        begin
            k_reg <= k_reg >> 1;
        end
    end

    assign left_out  = dec_reg ? b_reg : a_reg;
    assign right_out = dec_reg ? a_reg : b_reg;

endmodule

`default_nettype wire

/* hdl/simon_block_cipher_unit.sv */
// Simon block cipher, 64-bit block, 128-bit key, bit-serial round engine.
// Configuration: write cfg_data to register cfg_index with cfg_write high
// (0..3 key words, 4 round count, 5 z sequence select). Write only while
// busy is low. A key or sequence write marks the round key store stale.
// Command channel: an item is taken at a clock edge with start high and busy
// low; func selects encrypt (0) or decrypt (1).
// Result: left_half_out and right_half_out are valid for the single cycle in
// which done is high; the receiver has no way to hold them off.
// Sequence: after accept, the first round key is fetched and primed; each
// round then runs one word bit at a time through the shared one-bit round
// slice. A stale key store is first rebuilt, one round key per cycle into
// the key RAM. Zero rounds return the block in the next cycle.
// One item is in flight at a time; busy stays high until done.
// Reset: key words 0, 44 rounds, sequence 3, key store marked stale.
`default_nettype none

`include "assert_macros.svh"

module simon_block_cipher_unit
    import simon_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic                   func,
    input  wire logic [WORD_BITS-1:0]   left_half_in,
    input  wire logic [WORD_BITS-1:0]   right_half_in,
    output logic                        done,
    output logic [WORD_BITS-1:0]        left_half_out,
    output logic [WORD_BITS-1:0]        right_half_out
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_FETCH,
        ST_PRIME,
        ST_RUN
    } state_t;

    // configuration registers
    word_t [KEY_REGS-1:0]   key_word_reg;
    logic [ROUND_CNT_W-1:0] round_count_reg;
    logic [SEQ_W-1:0]       seq_sel_reg;
    logic                   sched_ready_reg;

    // sequencer state
    state_t            state_reg,   state_next;
    logic [ROUND_W-1:0] rounds_reg,  rounds_next;
    logic [ROUND_W-1:0] round_reg,   round_next;
    logic [BIT_W-1:0]   bit_reg,     bit_next;
    logic [KIDX_W-1:0]  key_idx_reg, key_idx_next;
    logic [KIDX_W-1:0]  last_idx_reg, last_idx_next;
    logic               dec_reg,     dec_next;
    logic               done_reg,    done_next;

    logic               accept;
    logic               bit_last;
    logic               sched_go;
    logic               sched_done;
    logic [ROUND_W-1:0] rounds_clamp;
    logic [KIDX_W-1:0]  rounds_top;
    logic [KIDX_W-1:0]  key_idx_step;
    key_wr_t            key_wr;
    word_t              key_rd;
    dp_ctrl_t           dp_ctrl;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign done   = done_reg;

    // configuration writes; key or sequence changes force a new schedule
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_word_reg    <= '0;
            round_count_reg <= ROUND_COUNT_RST;
            seq_sel_reg     <= SEQ_SELECT_RST;
            sched_ready_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index) inside
                REG_KEY_WORD_0, REG_KEY_WORD_1, REG_KEY_WORD_2, REG_KEY_WORD_3:
                begin
                    key_word_reg[cfg_index[1:0]] <= word_t'(cfg_data);
                    sched_ready_reg              <= 1'b0;
                end
                REG_ROUND_COUNT:
                begin
                    round_count_reg <= cfg_data[ROUND_CNT_W-1:0];
                end
                REG_SEQ_SELECT:
                begin
                    seq_sel_reg     <= cfg_data[SEQ_W-1:0];
                    sched_ready_reg <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
        else if (sched_done)
        begin
            sched_ready_reg <= 1'b1;
        end
    end

    // round count limited to the key store depth
    always_comb
    begin
        if (32'(round_count_reg) > MAX_ROUNDS)
        begin
            rounds_clamp = ROUND_W'(MAX_ROUNDS);
        end
        else
        begin
            rounds_clamp = ROUND_W'(round_count_reg);
        end
        rounds_top   = KIDX_W'(rounds_clamp - ROUND_W'(1));
        key_idx_step = dec_reg ? key_idx_reg - KIDX_W'(1) : key_idx_reg + KIDX_W'(1);
    end

    assign bit_last = (bit_reg == BIT_W'(WORD_BITS - 1));
    assign sched_go = accept && !sched_ready_reg && (rounds_clamp != '0);

    // datapath controls
    always_comb
    begin
        dp_ctrl.load       = accept;
        dp_ctrl.step       = (state_reg == ST_RUN);
        dp_ctrl.round_last = (state_reg == ST_RUN) && bit_last;
        dp_ctrl.key_load   = (state_reg == ST_PRIME) || dp_ctrl.round_last;
    end

    // sequencer next state
    always_comb
    begin
        state_next    = state_reg;
        rounds_next   = rounds_reg;
        round_next    = round_reg;
        bit_next      = bit_reg;
        key_idx_next  = key_idx_reg;
        last_idx_next = last_idx_reg;
        dec_next      = dec_reg;
        done_next     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rounds_next   = rounds_clamp;
                    round_next    = '0;
                    bit_next      = '0;
                    dec_next      = func;
                    key_idx_next  = func ? rounds_top : '0;
                    last_idx_next = func ? '0 : rounds_top;
                    if (rounds_clamp == '0)
                    begin
                        done_next = 1'b1;
                    end
                    else if (!sched_ready_reg)
                    begin
                        state_next = ST_EXPAND;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_EXPAND:
            begin
                if (sched_done)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_PRIME;
            end
            ST_PRIME:
            begin
                if (key_idx_reg != last_idx_reg)
                begin
                    key_idx_next = key_idx_step;
                end
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                bit_next = bit_reg + BIT_W'(1);
                if (bit_last)
                begin
                    if (key_idx_reg != last_idx_reg)
                    begin
                        key_idx_next = key_idx_step;
                    end
                    if (round_reg == rounds_reg - ROUND_W'(1))
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        round_next = round_reg + ROUND_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rounds_reg   <= '0;
            round_reg    <= '0;
            bit_reg      <= '0;
            key_idx_reg  <= '0;
            last_idx_reg <= '0;
            dec_reg      <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rounds_reg   <= rounds_next;
            round_reg    <= round_next;
            bit_reg      <= bit_next;
            key_idx_reg  <= key_idx_next;
            last_idx_reg <= last_idx_next;
            dec_reg      <= dec_next;
            done_reg     <= done_next;
        end
    end

    // round key expansion
    simon_key_sched u_key_sched (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (sched_go),
        .key_words (key_word_reg),
        .seq_sel   (seq_sel_reg),
        .key_wr    (key_wr),
        .done      (sched_done)
    );

    // round key store
    simon_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAX_ROUNDS)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (key_wr.en),
        .wr_addr (key_wr.addr),
        .wr_data (key_wr.data),
        .rd_addr (key_idx_reg),
        .rd_data (key_rd)
    );

    // bit-serial round engine
    simon_round_serial u_round (
        .clk       (clk),
        .ctrl      (dp_ctrl),
        .func      (func),
        .left_in   (left_half_in),
        .right_in  (right_half_in),
        .key       (key_rd),
        .left_out  (left_half_out),
        .right_out (right_half_out)
    );

    // checks
    `ASSERT_NOW(a_done_when_idle, !done_reg || (state_reg == ST_IDLE), "done outside idle")
    `ASSERT_NOW(a_key_write_in_expand, !key_wr.en || (state_reg == ST_EXPAND),
        "key store written outside expansion")
    `ASSERT_NEXT(a_accept_progress, accept, busy || done_reg, "accepted item dropped")
    `ASSERT_NOW(a_run_needs_schedule, (state_reg != ST_RUN) || sched_ready_reg,
        "rounds run on a stale key store")

endmodule

`default_nettype wire

/* tb/simon_block_cipher_unit_tb.sv */
`timescale 1ns / 1ps

module simon_block_cipher_unit_tb;
    import simon_pkg::*;

    // operation codes on func
    localparam logic FUNC_ENCRYPT = 1'b0;
    localparam logic FUNC_DECRYPT = 1'b1;

    // register indexes with no register behind them
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

    // key schedule constants
    localparam int    SEQ_LAST   = 4;
    localparam int    SEQ_RESET  = 3;
    localparam int    Z_BITS     = 62;
    localparam word_t SCHED_XOR  = 32'd3;

    // z sequences, first symbol in the top bit
    localparam bit [Z_BITS-1:0] Z_ROWS [5] = '{
        62'b11111010001001010110000111001101111101000100101011000011100110,
        62'b10001110111110010011000010110101000111011111001001100001011010,
        62'b10101111011100000011010010011000101000010001111110010110110011,
        62'b11011011101011000110010111100000010010001010011100110100001111,
        62'b11010001111001101011011000100000010111000011001010010011101111
    };

    // run shape
    localparam int ITEM_TOTAL    = 1100;
    localparam int IDLE_PCT      = 6;
    localparam int GAP_MAX       = 32 * MAX_ROUNDS + 8;
    localparam int SETTLE_CYCLES = 6;
    localparam int TAIL_CYCLES   = 64;
    localparam int CYCLE_LIMIT   = 10_000_000;
    localparam int REPORT_MAX    = 10;

    // cipher predictor and store of expected blocks
    class cipher_scoreboard;
        word_t                key_words [KEY_REGS];
        bit [ROUND_CNT_W-1:0] round_total;
        bit [SEQ_W-1:0]       seq_sel;
        word_t                round_keys [MAX_ROUNDS];
        bit                   keys_valid;
        word_t                want_left [$];
        word_t                want_right [$];
        int                   mismatches;

        function new();
            foreach (key_words[i])
                key_words[i] = '0;
            round_total = ROUND_CNT_W'(MAX_ROUNDS);
            seq_sel     = SEQ_W'(SEQ_RESET);
            keys_valid  = 1'b0;
            mismatches  = 0;
        endfunction

        function word_t rotl(word_t x, int r);
            return (x << r) | (x >> (WORD_BITS - r));
        endfunction

        function word_t rotr(word_t x, int r);
            return (x >> r) | (x << (WORD_BITS - r));
        endfunction

        function word_t feistel_mix(word_t x);
            return (rotl(x, 1) & rotl(x, 8)) ^ rotl(x, 2);
        endfunction

        function int pending();
            return want_left.size();
        endfunction

        // register write as the block sees it
        function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx) inside
                REG_KEY_WORD_0, REG_KEY_WORD_1, REG_KEY_WORD_2, REG_KEY_WORD_3:
                begin
                    key_words[idx[1:0]] = data;
                    keys_valid          = 1'b0;
                end
                REG_ROUND_COUNT:
                begin
                    round_total = data[ROUND_CNT_W-1:0];
                end
                REG_SEQ_SELECT:
                begin
                    seq_sel    = data[SEQ_W-1:0];
                    keys_valid = 1'b0;
                end
                default:
                begin
                end
            endcase
        endfunction

        // full round key expansion, unknown selectors use the last sequence
        function void expand_round_keys();
            int    sel;
            word_t t;
            bit    zb;
            sel = (seq_sel > SEQ_LAST) ? SEQ_LAST : int'(seq_sel);
            for (int i = 0; i < KEY_REGS; i++)
                round_keys[i] = key_words[KEY_REGS - 1 - i];
            for (int i = KEY_REGS; i < MAX_ROUNDS; i++)
            begin
                t  = rotr(round_keys[i - 1], 3) ^ round_keys[i - 3];
                t  = t ^ rotr(t, 1);
                zb = Z_ROWS[sel][Z_BITS - 1 - ((i - KEY_REGS) % Z_BITS)];
                round_keys[i] = ~round_keys[i - KEY_REGS] ^ t ^ word_t'(zb) ^ SCHED_XOR;
            end
            keys_valid = 1'b1;
        endfunction

        // accepted item: work out the block it must return
        function void note_block(logic op, word_t left, word_t right);
            word_t x;
            word_t y;
            word_t t;
            int    n;
            if (!keys_valid)
                expand_round_keys();
            n = (round_total > MAX_ROUNDS) ? MAX_ROUNDS : int'(round_total);
            x = left;
            y = right;
            if (op == FUNC_ENCRYPT)
            begin
                for (int i = 0; i < n; i++)
                begin
                    t = x;
                    x = feistel_mix(x) ^ round_keys[i] ^ y;
                    y = t;
                end
            end
            else
            begin
                for (int i = n; i > 0; i--)
                begin
                    t = y;
                    y = feistel_mix(y) ^ round_keys[i - 1] ^ x;
                    x = t;
                end
            end
            want_left.push_back(x);
            want_right.push_back(y);
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("%0t: mismatch: %s", $realtime, what);
        endfunction

        // returned block against the oldest expectation
        function void check_block(word_t left, word_t right);
            word_t el;
            word_t er;
            if (want_left.size() == 0)
            begin
                flag($sformatf("unexpected block %h %h", left, right));
                return;
            end
            el = want_left.pop_front();
            er = want_right.pop_front();
            if (left !== el)
                flag($sformatf("left_half_out expected %h actual %h", el, left));
            if (right !== er)
                flag($sformatf("right_half_out expected %h actual %h", er, right));
        endfunction
    endclass

    typedef struct {
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  data;
    } reg_write_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   start = 1'b0;
    logic                   busy;
    logic                   func = FUNC_ENCRYPT;
    logic [WORD_BITS-1:0]   left_half_in = '0;
    logic [WORD_BITS-1:0]   right_half_in = '0;
    logic                   done;
    logic [WORD_BITS-1:0]   left_half_out;
    logic [WORD_BITS-1:0]   right_half_out;

    cipher_scoreboard sb;
    reg_write_t       reg_plan [$];
    int               items_sent = 0;
    int               cycle_count = 0;
    bit               steady = 1'b0;

    simon_block_cipher_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .start          (start),
        .busy           (busy),
        .func           (func),
        .left_half_in   (left_half_in),
        .right_half_in  (right_half_in),
        .done           (done),
        .left_half_out  (left_half_out),
        .right_half_out (right_half_out)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_block(left_half_out, right_half_out);
    end

    function automatic word_t draw_word();
        int pick;
        pick = $urandom_range(99);
        if (pick < 5)
            return '0;
        else if (pick < 10)
            return '1;
        return $urandom();
    endfunction

    function automatic void plan_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        reg_write_t w;
        w.idx  = idx;
        w.data = data;
        reg_plan.push_back(w);
    endfunction

    // back-to-back register writes from the plan
    task automatic program_regs();
        foreach (reg_plan[i])
        begin
            cfg_write <= 1'b1;
            cfg_index <= reg_plan[i].idx;
            cfg_data  <= reg_plan[i].data;
            @(posedge clk);
            sb.set_register(reg_plan[i].idx, reg_plan[i].data);
        end
        cfg_write <= 1'b0;
        reg_plan.delete();
    endtask

    // present one item, leave start high after it is taken
    task automatic send_block(input logic op, input word_t left, input word_t right);
        int gap;
        gap = 0;
        steady = (items_sent >= 400) && (items_sent < 650);
        if (!steady && $urandom_range(99) < IDLE_PCT)
            gap = $urandom_range(1, GAP_MAX);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start         <= 1'b1;
        func          <= op;
        left_half_in  <= left;
        right_half_in <= right;
        do
            @(posedge clk);
        while (busy);
        sb.note_block(op, left, right);
        items_sent++;
    endtask

    // stop sending and wait until every block is back
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0 || busy);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int                   n;
        int                   pick;
        logic [ROUND_CNT_W-1:0] rc;
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset configuration
        send_block(FUNC_ENCRYPT, '0, '0);
        send_block(FUNC_DECRYPT, '1, '1);
        drain();

        // published key, full rounds, field extremes
        plan_write(REG_KEY_WORD_0, 32'h1b1a1918);
        plan_write(REG_KEY_WORD_1, 32'h13121110);
        plan_write(REG_KEY_WORD_2, 32'h0b0a0908);
        plan_write(REG_KEY_WORD_3, 32'h03020100);
        plan_write(REG_ROUND_COUNT, 32'd44);
        plan_write(REG_SEQ_SELECT, 32'd3);
        program_regs();
        send_block(FUNC_ENCRYPT, 32'h656b696c, 32'h20646e75);
        send_block(FUNC_DECRYPT, 32'h44c8fc20, 32'hb9dfa07a);
        send_block(FUNC_ENCRYPT, '0, '1);
        send_block(FUNC_DECRYPT, '1, '0);
        send_block(FUNC_ENCRYPT, 32'haaaaaaaa, 32'h55555555);
        send_block(FUNC_DECRYPT, 32'h55555555, 32'haaaaaaaa);
        drain();

        // zero rounds pass the block through
        plan_write(REG_ROUND_COUNT, 32'hffffffc0);
        program_regs();
        send_block(FUNC_ENCRYPT, 32'h01234567, 32'h89abcdef);
        send_block(FUNC_DECRYPT, 32'hfedcba98, 32'h76543210);
        drain();

        // round count above the maximum, selector beyond the last sequence
        plan_write(REG_KEY_WORD_0, '1);
        plan_write(REG_KEY_WORD_1, '1);
        plan_write(REG_KEY_WORD_2, '1);
        plan_write(REG_KEY_WORD_3, '1);
        plan_write(REG_ROUND_COUNT, 32'h0000003f);
        plan_write(REG_SEQ_SELECT, 32'hfffffff7);
        program_regs();
        send_block(FUNC_ENCRYPT, 32'h80000001, 32'h7ffffffe);
        send_block(FUNC_DECRYPT, 32'h12345678, 32'h9abcdef0);
        drain();

        // single round, first sequence, writes to unused indexes
        plan_write(REG_KEY_WORD_0, '0);
        plan_write(REG_KEY_WORD_1, '0);
        plan_write(REG_KEY_WORD_2, '0);
        plan_write(REG_KEY_WORD_3, '0);
        plan_write(REG_ROUND_COUNT, 32'd1);
        plan_write(REG_SEQ_SELECT, 32'd0);
        plan_write(REG_SPARE_6, '1);
        plan_write(REG_SPARE_7, '1);
        program_regs();
        send_block(FUNC_ENCRYPT, 32'hdeadbeef, 32'h0badf00d);
        send_block(FUNC_DECRYPT, 32'hcafef00d, 32'h31415926);
        drain();

        // last sequence, one round past the maximum
        plan_write(REG_SEQ_SELECT, 32'd4);
        plan_write(REG_ROUND_COUNT, 32'd45);
        program_regs();
        send_block(FUNC_ENCRYPT, 32'h0f0f0f0f, 32'hf0f0f0f0);
        send_block(FUNC_DECRYPT, 32'hf0f0f0f0, 32'h0f0f0f0f);

        // random phases
        while (items_sent < ITEM_TOTAL)
        begin
            drain();
            if ($urandom_range(9) == 0)
                plan_write($urandom_range(1) ? REG_SPARE_6 : REG_SPARE_7, $urandom());
            for (int r = 0; r < KEY_REGS; r++)
                if ($urandom_range(1))
                    plan_write(REG_KEY_WORD_0 + CFG_INDEX_W'(r), draw_word());
            if ($urandom_range(3) != 0)
            begin
                pick = $urandom_range(99);
                if (pick < 4)
                    rc = '0;
                else if (pick < 8)
                    rc = ROUND_CNT_W'($urandom_range(MAX_ROUNDS + 1, 63));
                else if (pick < 14)
                    rc = ROUND_CNT_W'(MAX_ROUNDS);
                else if (pick < 20)
                    rc = ROUND_CNT_W'(1);
                else
                    rc = ROUND_CNT_W'($urandom_range(1, MAX_ROUNDS));
                plan_write(REG_ROUND_COUNT, ($urandom() & ~32'h3f) | CFG_DATA_W'(rc));
            end
            if ($urandom_range(1))
                plan_write(REG_SEQ_SELECT,
                           ($urandom() & ~32'h7) | CFG_DATA_W'($urandom_range(0, 7)));
            program_regs();
            n = $urandom_range(8, 40);
            for (int k = 0; k < n; k++)
            begin
                // pause mid-phase until all blocks are back
                if (k == n / 2 && $urandom_range(4) == 0)
                    drain();
                send_block($urandom_range(1) ? FUNC_DECRYPT : FUNC_ENCRYPT,
                           draw_word(), draw_word());
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
